[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; pulled in by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/iee_pkg.sv]
// Shared widths, codes, unit interface types and saturation helpers.
// No dependencies; used by every module of the evaluator.
package iee_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int OP_W   = 3;
    localparam int PROD_W = 2 * DATA_W;
    localparam int QUO_W  = DATA_W + FRAC_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    // operator codes; 5..7 behave as end
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_END = 3'd4;

    // pending scale operation
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_MUL  = 2'd1;
    localparam logic [1:0] PEND_DIV  = 2'd2;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] LIM_NEG = {{(PROD_W-DATA_W){1'b0}}, VAL_MIN};
    localparam logic [PROD_W-1:0] LIM_POS = {{(PROD_W-DATA_W){1'b0}}, VAL_MAX};

    typedef enum logic [2:0] {
        US_IDLE = 3'b001,
        US_RUN  = 3'b010,
        US_DONE = 3'b100
    } unit_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } scale_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
        logic              ovf;
        logic              dz;
    } scale_rsp_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } sat_t;

    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    // saturate a magnitude to the signed range and apply the sign
    function automatic sat_t pack_mag(input logic neg, input logic [PROD_W-1:0] mag);
        logic [PROD_W-1:0] limit;
        logic [DATA_W-1:0] v;
        sat_t              r;
        limit   = neg ? LIM_NEG : LIM_POS;
        r.ovf   = (mag > limit);
        v       = r.ovf ? limit[DATA_W-1:0] : mag[DATA_W-1:0];
        r.value = neg ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

[sv/iee_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, Q-format rescale.
// Depends on iee_pkg.
module iee_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  iee_pkg::scale_req_t req,
    output iee_pkg::scale_rsp_t rsp
);

    iee_pkg::unit_state_t              state_reg, state_next;
    logic [iee_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [iee_pkg::DATA_W-1:0]        ma_reg, ma_next;
    logic                              neg_reg, neg_next;
    logic [iee_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [iee_pkg::DATA_W:0]          partial;
    iee_pkg::sat_t                     packed_res;

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        ma_next    = ma_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        partial    = {1'b0, prod_reg[iee_pkg::PROD_W-1:iee_pkg::DATA_W]}
                   + (prod_reg[0] ? {1'b0, ma_reg} : '0);
        unique case (state_reg)
            iee_pkg::US_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = {{iee_pkg::DATA_W{1'b0}}, iee_pkg::mag_of(req.b)};
                    ma_next    = iee_pkg::mag_of(req.a);
                    neg_next   = req.a[iee_pkg::DATA_W-1] ^ req.b[iee_pkg::DATA_W-1];
                    cnt_next   = iee_pkg::CNT_W'(iee_pkg::DATA_W - 1);
                    state_next = iee_pkg::US_RUN;
                end
            end
            iee_pkg::US_RUN:
            begin
                prod_next = {partial, prod_reg[iee_pkg::DATA_W-1:1]};
                if (cnt_reg == '0)
                    state_next = iee_pkg::US_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            iee_pkg::US_DONE:
            begin
                state_next = iee_pkg::US_IDLE;
            end
            default:
            begin
                state_next = iee_pkg::US_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iee_pkg::US_IDLE;
            prod_reg  <= '0;
            ma_reg    <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
            ma_reg    <= ma_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign packed_res = iee_pkg::pack_mag(neg_reg, prod_reg >> iee_pkg::FRAC_W);

    assign rsp.done  = (state_reg == iee_pkg::US_DONE);
    assign rsp.value = packed_res.value;
    assign rsp.ovf   = packed_res.ovf;
    assign rsp.dz    = 1'b0;

endmodule

[sv/iee_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, Q-format prescale.
// Depends on iee_pkg.
module iee_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  iee_pkg::scale_req_t req,
    output iee_pkg::scale_rsp_t rsp
);

    iee_pkg::unit_state_t              state_reg, state_next;
    logic [iee_pkg::QUO_W-1:0]         num_reg, num_next;
    logic [iee_pkg::DATA_W-1:0]        rem_reg, rem_next;
    logic [iee_pkg::DATA_W-1:0]        d_reg, d_next;
    logic                              neg_reg, neg_next;
    logic                              dz_reg, dz_next;
    logic [iee_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [iee_pkg::DATA_W:0]          shifted;
    logic [iee_pkg::DATA_W:0]          diff;
    logic                              fits;
    logic [iee_pkg::DATA_W-1:0]        mb;
    iee_pkg::sat_t                     packed_res;

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        cnt_next   = cnt_reg;
        mb         = iee_pkg::mag_of(req.b);
        shifted    = {rem_reg, num_reg[iee_pkg::QUO_W-1]};
        diff       = shifted - {1'b0, d_reg};
        fits       = (shifted >= {1'b0, d_reg});
        unique case (state_reg)
            iee_pkg::US_IDLE:
            begin
                if (req.start)
                begin
                    if (mb == '0)
                    begin
                        // zero divisor: saturate on dividend sign
                        dz_next    = 1'b1;
                        neg_next   = req.a[iee_pkg::DATA_W-1];
                        state_next = iee_pkg::US_DONE;
                    end
                    else
                    begin
                        dz_next    = 1'b0;
                        neg_next   = req.a[iee_pkg::DATA_W-1] ^ req.b[iee_pkg::DATA_W-1];
                        num_next   = iee_pkg::QUO_W'(iee_pkg::mag_of(req.a))
                                     << iee_pkg::FRAC_W;
                        rem_next   = '0;
                        d_next     = mb;
                        cnt_next   = iee_pkg::CNT_W'(iee_pkg::QUO_W - 1);
                        state_next = iee_pkg::US_RUN;
                    end
                end
            end
            iee_pkg::US_RUN:
            begin
                rem_next = fits ? diff[iee_pkg::DATA_W-1:0] : shifted[iee_pkg::DATA_W-1:0];
                num_next = {num_reg[iee_pkg::QUO_W-2:0], fits};
                if (cnt_reg == '0)
                    state_next = iee_pkg::US_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            iee_pkg::US_DONE:
            begin
                state_next = iee_pkg::US_IDLE;
            end
            default:
            begin
                state_next = iee_pkg::US_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iee_pkg::US_IDLE;
            num_reg   <= '0;
            rem_reg   <= '0;
            d_reg     <= '0;
            neg_reg   <= 1'b0;
            dz_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            rem_reg   <= rem_next;
            d_reg     <= d_next;
            neg_reg   <= neg_next;
            dz_reg    <= dz_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign packed_res = iee_pkg::pack_mag(neg_reg, iee_pkg::PROD_W'(num_reg));

    assign rsp.done  = (state_reg == iee_pkg::US_DONE);
    assign rsp.value = dz_reg ? (neg_reg ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX)
                              : packed_res.value;
    assign rsp.ovf   = dz_reg ? 1'b0 : packed_res.ovf;
    assign rsp.dz    = dz_reg;

endmodule

[sv/infix_expression_evaluator_unit.sv]
// Infix evaluator top: control, sum/term state, output register; uses iee_pkg,
// iee_mul, iee_div and assert_macros.svh.
// Requests are taken only in IDLE, so one request is in flight at a time; after a multiply
// or divide the next request waits until the scale unit has finished.
// An end result waits in FIN while the output register is held by out_stall.
// rst_n asynchronous, active low: clears sum, term, flags and the output register.
`include "assert_macros.svh"

module infix_expression_evaluator_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [iee_pkg::DATA_W-1:0]    operand_value,
    input  logic        [iee_pkg::OP_W-1:0]      operator_code,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [iee_pkg::DATA_W-1:0]    expression_value,
    output logic                                 overflow_flag,
    output logic                                 divide_by_zero_flag
);

    localparam int SUM_W = iee_pkg::DATA_W + 2;

    // IDLE takes a request, SCALE waits on mul/div, FIN folds the term, parks the op or emits the result
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCALE = 3'b010,
        ST_FIN   = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [iee_pkg::DATA_W-1:0]      sum_reg, sum_next;
    logic [iee_pkg::DATA_W-1:0]      term_reg, term_next;
    logic                            tsign_reg, tsign_next;
    logic [1:0]                      pend_reg, pend_next;
    logic                            ovf_reg, ovf_next;
    logic                            dz_reg, dz_next;
    logic [iee_pkg::OP_W-1:0]        op_reg, op_next;

    logic                            out_valid_reg, out_valid_next;
    logic [iee_pkg::DATA_W-1:0]      out_value_reg, out_value_next;
    logic                            out_ovf_reg, out_ovf_next;
    logic                            out_dz_reg, out_dz_next;

    iee_pkg::scale_req_t             mul_req, div_req;
    iee_pkg::scale_rsp_t             mul_rsp, div_rsp, rsp;

    logic                            in_acc;
    logic                            out_busy;
    logic [iee_pkg::DATA_W-1:0]      tmag;
    logic                            eff_neg;
    logic signed [SUM_W-1:0]         addend;
    logic signed [SUM_W-1:0]         sum_wide;
    logic signed [SUM_W-1:0]         sum_max;
    logic signed [SUM_W-1:0]         sum_min;
    logic [iee_pkg::DATA_W-1:0]      sum_sat;
    logic                            sum_ovf;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;

    // the scale unit picks up the held term and the arriving operand
    assign mul_req.start = in_acc && (pend_reg == iee_pkg::PEND_MUL);
    assign mul_req.a     = term_reg;
    assign mul_req.b     = operand_value;
    assign div_req.start = in_acc && (pend_reg == iee_pkg::PEND_DIV);
    assign div_req.a     = term_reg;
    assign div_req.b     = operand_value;

    iee_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    iee_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rsp = mul_rsp.done ? mul_rsp : div_rsp;

    // signed add of the finished term into the running sum, saturating
    always_comb
    begin
        tmag     = iee_pkg::mag_of(term_reg);
        eff_neg  = tsign_reg ^ term_reg[iee_pkg::DATA_W-1];
        addend   = eff_neg ? -$signed(SUM_W'(tmag)) : $signed(SUM_W'(tmag));
        sum_wide = $signed({{2{sum_reg[iee_pkg::DATA_W-1]}}, sum_reg}) + addend;
        sum_max  = $signed({2'b00, iee_pkg::VAL_MAX});
        sum_min  = $signed({2'b11, iee_pkg::VAL_MIN});
        sum_ovf  = 1'b0;
        sum_sat  = sum_wide[iee_pkg::DATA_W-1:0];
        if (sum_wide > sum_max)
        begin
            sum_sat = iee_pkg::VAL_MAX;
            sum_ovf = 1'b1;
        end
        else if (sum_wide < sum_min)
        begin
            sum_sat = iee_pkg::VAL_MIN;
            sum_ovf = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        tsign_next     = tsign_reg;
        pend_next      = pend_reg;
        ovf_next       = ovf_reg;
        dz_next        = dz_reg;
        op_next        = op_reg;
        out_valid_next = out_busy;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;
        out_dz_next    = out_dz_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = operator_code;
                    if (pend_reg == iee_pkg::PEND_MUL || pend_reg == iee_pkg::PEND_DIV)
                        state_next = ST_SCALE;
                    else
                    begin
                        // no pending op: operand opens a new term
                        term_next  = operand_value;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCALE:
            begin
                if (rsp.done)
                begin
                    term_next  = rsp.value;
                    ovf_next   = ovf_reg | rsp.ovf;
                    dz_next    = dz_reg | rsp.dz;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                unique case (op_reg)
                    iee_pkg::OP_MUL:
                    begin
                        pend_next  = iee_pkg::PEND_MUL;
                        state_next = ST_IDLE;
                    end
                    iee_pkg::OP_DIV:
                    begin
                        pend_next  = iee_pkg::PEND_DIV;
                        state_next = ST_IDLE;
                    end
                    iee_pkg::OP_ADD, iee_pkg::OP_SUB:
                    begin
                        sum_next   = sum_sat;
                        ovf_next   = ovf_reg | sum_ovf;
                        tsign_next = (op_reg == iee_pkg::OP_SUB);
                        pend_next  = iee_pkg::PEND_NONE;
                        term_next  = '0;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        // end (and unused codes): emit once the output slot frees up
                        if (!out_busy)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = sum_sat;
                            out_ovf_next   = ovf_reg | sum_ovf;
                            out_dz_next    = dz_reg;
                            sum_next       = '0;
                            term_next      = '0;
                            tsign_next     = 1'b0;
                            pend_next      = iee_pkg::PEND_NONE;
                            ovf_next       = 1'b0;
                            dz_next        = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            term_reg      <= '0;
            tsign_reg     <= 1'b0;
            pend_reg      <= iee_pkg::PEND_NONE;
            ovf_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            op_reg        <= iee_pkg::OP_END;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_ovf_reg   <= 1'b0;
            out_dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            tsign_reg     <= tsign_next;
            pend_reg      <= pend_next;
            ovf_reg       <= ovf_next;
            dz_reg        <= dz_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_ovf_reg   <= out_ovf_next;
            out_dz_reg    <= out_dz_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign expression_value    = out_value_reg;
    assign overflow_flag       = out_ovf_reg;
    assign divide_by_zero_flag = out_dz_reg;

    // an accepted request always leaves IDLE
    `ASSERT_NEXT(a_acc_leaves_idle, clk, rst_n, in_acc, state_reg != ST_IDLE)
    // the multiplier never finishes together with the divider, and only while awaited
    `ASSERT_IMPL(a_one_unit_done, clk, rst_n, mul_rsp.done,
                 !div_rsp.done && state_reg == ST_SCALE)
    // an end request with a free output slot shows a result next cycle
    `ASSERT_NEXT(a_end_emits, clk, rst_n,
                 state_reg == ST_FIN && op_reg != iee_pkg::OP_ADD && op_reg != iee_pkg::OP_SUB
                 && op_reg != iee_pkg::OP_MUL && op_reg != iee_pkg::OP_DIV && !out_busy,
                 out_valid_reg)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Bench for infix_expression_evaluator_unit: directed and random infix expressions,
// each result checked against a local model of the two-level fixed-point evaluation.
// Depends on iee_pkg and the evaluator RTL.

module tb_top;

    // one expression element as it crosses the input channel
    typedef struct packed {
        logic [iee_pkg::DATA_W-1:0] operand;
        logic [iee_pkg::OP_W-1:0]   op;
    } element_t;

    // one completed expression as it leaves the output channel
    typedef struct packed {
        logic [iee_pkg::DATA_W-1:0] value;
        logic                       ovf;
        logic                       dz;
    } eval_result_t;

    // Q16.16 constants used by the directed expressions
    localparam logic [iee_pkg::DATA_W-1:0] FX_ONE       = 32'h0001_0000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_ONE_HALF  = 32'h0001_8000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_TWO       = 32'h0002_0000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_MINUS_TWO = 32'hFFFE_0000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_THREE     = 32'h0003_0000;
    localparam logic [iee_pkg::DATA_W-1:0] FX_SEVEN     = 32'h0007_0000;

    // signed range of the running sum
    localparam longint SUM_HI = (longint'(1) <<< (iee_pkg::DATA_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (iee_pkg::DATA_W - 1));

    // operators that may sit inside an expression
    localparam logic [iee_pkg::OP_W-1:0] MID_OPS [4] =
        '{iee_pkg::OP_ADD, iee_pkg::OP_SUB, iee_pkg::OP_MUL, iee_pkg::OP_DIV};

    logic                       clk                 = 1'b0;
    logic                       rst_n               = 1'b0;
    logic                       in_valid            = 1'b0;
    logic                       in_stall;
    logic [iee_pkg::DATA_W-1:0] operand_value       = '0;
    logic [iee_pkg::OP_W-1:0]   operator_code       = iee_pkg::OP_END;
    logic                       out_valid;
    logic                       out_stall           = 1'b0;
    logic [iee_pkg::DATA_W-1:0] expression_value;
    logic                       overflow_flag;
    logic                       divide_by_zero_flag;

    // idle rates in percent, changed per phase
    int tx_idle_pct = 29;
    int rx_idle_pct = 45;

    // request accepted at the last rising edge
    logic in_taken = 1'b0;

    element_t     element_q[$];   // elements waiting to be driven
    eval_result_t result_q[$];    // expression results still owed by the block
    int           queued_cnt   = 0;
    int           mismatch_cnt = 0;

    // model state of the expression in progress
    logic [iee_pkg::DATA_W-1:0] sum_acc      = '0;
    logic [iee_pkg::DATA_W-1:0] term_acc     = '0;
    logic                       term_negated = 1'b0;
    logic [1:0]                 scale_pend   = iee_pkg::PEND_NONE;
    logic                       ovf_sticky   = 1'b0;
    logic                       dz_sticky    = 1'b0;

    infix_expression_evaluator_unit i_dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .operand_value       (operand_value),
        .operator_code       (operator_code),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .expression_value    (expression_value),
        .overflow_flag       (overflow_flag),
        .divide_by_zero_flag (divide_by_zero_flag)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Expression model
    // ------------------------------------------------------------------

    function automatic void clear_expression();
        sum_acc      = '0;
        term_acc     = '0;
        term_negated = 1'b0;
        scale_pend   = iee_pkg::PEND_NONE;
        ovf_sticky   = 1'b0;
        dz_sticky    = 1'b0;
    endfunction

    // absolute value, zero-extended; the most negative value maps to 2^(W-1)
    function automatic logic [63:0] magnitude64(input logic [iee_pkg::DATA_W-1:0] x);
        logic [iee_pkg::DATA_W-1:0] neg_x;
        neg_x = ~x + 1'b1;
        return x[iee_pkg::DATA_W-1] ? 64'(neg_x) : 64'(x);
    endfunction

    // apply sign to a magnitude, saturating to the signed range
    function automatic logic [iee_pkg::DATA_W-1:0] clamp_signed(input logic        neg,
                                                                input logic [63:0] mag);
        logic [63:0]                limit;
        logic [iee_pkg::DATA_W-1:0] v;
        logic [iee_pkg::DATA_W-1:0] neg_v;
        limit = neg ? (64'd1 << (iee_pkg::DATA_W - 1))
                    : (64'd1 << (iee_pkg::DATA_W - 1)) - 64'd1;
        if (mag > limit)
        begin
            ovf_sticky = 1'b1;
            v = limit[iee_pkg::DATA_W-1:0];
        end
        else
            v = mag[iee_pkg::DATA_W-1:0];
        neg_v = ~v + 1'b1;
        return neg ? neg_v : v;
    endfunction

    // Fold one accepted element into the expression. Returns 1 with the result
    // when the element closes the expression (end, or any code above end).
    function automatic logic fold_element(input element_t e, output eval_result_t r);
        logic        a_neg;
        logic        b_neg;
        logic        t_neg;
        logic        sub_term;
        logic [63:0] a_mag;
        logic [63:0] b_mag;
        logic [63:0] t_mag;
        longint      total;
        r     = '0;
        a_neg = term_acc[iee_pkg::DATA_W-1];
        b_neg = e.operand[iee_pkg::DATA_W-1];
        a_mag = magnitude64(term_acc);
        b_mag = magnitude64(e.operand);

        // product and quotient magnitudes are truncated toward zero
        case (scale_pend)
            iee_pkg::PEND_MUL:
                term_acc = clamp_signed(a_neg ^ b_neg, (a_mag * b_mag) >> iee_pkg::FRAC_W);
            iee_pkg::PEND_DIV:
                if (b_mag == 64'd0)
                begin
                    // zero divisor: saturate by dividend sign, no overflow
                    dz_sticky = 1'b1;
                    term_acc  = a_neg ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX;
                end
                else
                    term_acc = clamp_signed(a_neg ^ b_neg,
                                            (a_mag << iee_pkg::FRAC_W) / b_mag);
            default:
                term_acc = e.operand;
        endcase

        if (e.op == iee_pkg::OP_MUL)
        begin
            scale_pend = iee_pkg::PEND_MUL;
            return 1'b0;
        end
        if (e.op == iee_pkg::OP_DIV)
        begin
            scale_pend = iee_pkg::PEND_DIV;
            return 1'b0;
        end

        // term is finished: add or subtract it, saturating the sum
        t_mag    = magnitude64(term_acc);
        t_neg    = term_acc[iee_pkg::DATA_W-1] && (t_mag != 64'd0);
        sub_term = term_negated ? !t_neg : t_neg;
        total    = longint'(signed'(sum_acc)) + (sub_term ? -longint'(t_mag) : longint'(t_mag));
        if (total > SUM_HI)
        begin
            ovf_sticky = 1'b1;
            total = SUM_HI;
        end
        else if (total < SUM_LO)
        begin
            ovf_sticky = 1'b1;
            total = SUM_LO;
        end
        sum_acc    = total[iee_pkg::DATA_W-1:0];
        scale_pend = iee_pkg::PEND_NONE;
        term_acc   = '0;

        if (e.op == iee_pkg::OP_ADD)
        begin
            term_negated = 1'b0;
            return 1'b0;
        end
        if (e.op == iee_pkg::OP_SUB)
        begin
            term_negated = 1'b1;
            return 1'b0;
        end

        r.value = sum_acc;
        r.ovf   = ovf_sticky;
        r.dz    = dz_sticky;
        clear_expression();
        return 1'b1;
    endfunction

    function automatic void report_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_element(input logic [iee_pkg::DATA_W-1:0] v,
                                         input logic [iee_pkg::OP_W-1:0]   op);
        element_t e;
        e.operand = v;
        e.op      = op;
        element_q.push_back(e);
        queued_cnt++;
    endfunction

    // mostly small values so results stay in range; extremes and zeros mixed in
    function automatic logic [iee_pkg::DATA_W-1:0] pick_operand();
        logic [iee_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 15))
            0, 1:    v = '0;
            2:       v = iee_pkg::VAL_MAX;
            3:       v = iee_pkg::VAL_MIN;
            4:       v = FX_ONE;
            5:       v = FX_MINUS_ONE;
            6, 7, 8: v = $urandom();
            default:
            begin
                v = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 1'b1;
            end
        endcase
        return v;
    endfunction

    // one complete expression; occasionally closed by a code above end
    function automatic void push_expression();
        int n_elems;
        n_elems = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (int i = 0; i < n_elems - 1; i++)
            push_element(pick_operand(), MID_OPS[$urandom_range(0, 3)]);
        if ($urandom_range(0, 7) == 0)
            push_element(pick_operand(),
                         iee_pkg::OP_END + iee_pkg::OP_W'($urandom_range(1, 3)));
        else
            push_element(pick_operand(), iee_pkg::OP_END);
    endfunction

    function automatic void push_random(input int n_elems);
        int start_cnt;
        start_cnt = queued_cnt;
        while (queued_cnt - start_cnt < n_elems)
            push_expression();
    endfunction

    // sender holds off until the block has delivered everything it owes
    task automatic wait_drained();
        while (element_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: a new request only once the previous one was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        element_t e;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (element_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                e = element_q.pop_front();
                in_valid      <= 1'b1;
                operand_value <= e.operand;
                operator_code <= e.op;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, independent of out_valid
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

    // ------------------------------------------------------------------
    // Monitor: predict on accepted requests, check on accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        element_t     elem;
        eval_result_t r;
        eval_result_t got;
        eval_result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                elem.operand = operand_value;
                elem.op      = operator_code;
                if (fold_element(elem, r))
                    result_q.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                got.value = expression_value;
                got.ovf   = overflow_flag;
                got.dz    = divide_by_zero_flag;
                if (result_q.size() == 0)
                    report_error($sformatf("unexpected result value=%h ovf=%b dz=%b",
                                           got.value, got.ovf, got.dz));
                else
                begin
                    want = result_q.pop_front();
                    if (got.value !== want.value || got.ovf !== want.ovf || got.dz !== want.dz)
                        report_error($sformatf({"result mismatch: expected value=%h ovf=%b dz=%b,",
                                                " got value=%h ovf=%b dz=%b"},
                                               want.value, want.ovf, want.dz,
                                               got.value, got.ovf, got.dz));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 1: sender idles 29%, receiver 45%
        tx_idle_pct = 29;
        rx_idle_pct = 45;

        // lone zero
        push_element('0, iee_pkg::OP_END);
        // positive sum overflow
        push_element(iee_pkg::VAL_MAX, iee_pkg::OP_ADD);
        push_element(iee_pkg::VAL_MAX, iee_pkg::OP_END);
        // negative difference overflow
        push_element(iee_pkg::VAL_MIN, iee_pkg::OP_SUB);
        push_element(FX_ONE, iee_pkg::OP_END);
        // precedence: 1.5 + 2*3
        push_element(FX_ONE_HALF, iee_pkg::OP_ADD);
        push_element(FX_TWO, iee_pkg::OP_MUL);
        push_element(FX_THREE, iee_pkg::OP_END);
        // negative dividend over zero
        push_element(FX_MINUS_ONE, iee_pkg::OP_DIV);
        push_element('0, iee_pkg::OP_END);
        // positive dividend over zero
        push_element(FX_ONE, iee_pkg::OP_DIV);
        push_element('0, iee_pkg::OP_END);
        // zero over zero, then a following subtract
        push_element('0, iee_pkg::OP_DIV);
        push_element('0, iee_pkg::OP_SUB);
        push_element(FX_ONE, iee_pkg::OP_END);
        // product overflow
        push_element(iee_pkg::VAL_MIN, iee_pkg::OP_MUL);
        push_element(iee_pkg::VAL_MIN, iee_pkg::OP_END);
        // most negative over minus one
        push_element(iee_pkg::VAL_MIN, iee_pkg::OP_DIV);
        push_element(FX_MINUS_ONE, iee_pkg::OP_END);
        // codes above end close the expression
        push_element(FX_SEVEN, iee_pkg::OP_DIV);
        push_element(FX_TWO, iee_pkg::OP_END + iee_pkg::OP_W'(1));
        push_element(FX_THREE, iee_pkg::OP_END + iee_pkg::OP_W'(2));
        push_element(FX_MINUS_TWO, iee_pkg::OP_END + iee_pkg::OP_W'(3));

        push_random(280);
        wait_drained();

        // phase 2: sender idles 45%, receiver 29%
        tx_idle_pct = 45;
        rx_idle_pct = 29;
        push_random(300);
        wait_drained();

        // phase 3: no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random(300);
        wait_drained();

        // the slowest request is a divide
        repeat (80) @(posedge clk);

        if (result_q.size() != 0)
            report_error($sformatf("%0d results never arrived", result_q.size()));

        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/iee_pkg.sv
sv/iee_mul.sv
sv/iee_div.sv
sv/infix_expression_evaluator_unit.sv
dv/tb_top.sv
